// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL that carries checks.
// Each macro places one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fr_pkg.sv =====
`default_nettype none

package fr_pkg;

    // Fixed header geometry: magic, id high, id low, index, count.
    localparam int HEADER_BYTES = 5;

    // Default size of the reassembly store in bytes.
    localparam int BUFFER_BYTES_DEFAULT = 512;

    // Depth of the result queue in front of the output port.
    localparam int QUEUE_DEPTH = 3;

    // Operation selector carried with each input transaction.
    localparam logic OP_FRAGMENT = 1'b0;
    localparam logic OP_READ     = 1'b1;

    // Verdict on the fragment currently being received.
    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_REJECT = 2'd1,
        VERDICT_SEQERR = 2'd2
    } verdict_t;

    // Status reported at the end of a fragment.
    typedef enum logic [1:0] {
        STATUS_ERROR      = 2'd0,
        STATUS_INCOMPLETE = 2'd1,
        STATUS_COMPLETE   = 2'd2
    } status_t;

    // One result transaction.
    typedef struct packed {
        logic       is_read;
        logic [7:0] read_data;
        logic [9:0] frame_len;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fr_store.sv =====
`default_nettype none

module fr_store
    import fr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    input  wire logic [7:0]                      wr_data,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
    output logic      [7:0]                      rd_data
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] q_reg;
    logic       hit_reg;

    // Synchronous write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // Marks a cycle in which the read register holds an answer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= rd_en;
        end
    end

    // A read that missed the store, and every verdict, sees zero.
    assign rd_data = hit_reg ? q_reg : 8'd0;

endmodule

`default_nettype wire

// ===== rtl/core/fr_ctrl.sv =====
`default_nettype none

module fr_ctrl
    import fr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [7:0]                      cfg_data,
    input  wire logic                            item_accept,
    input  wire logic                            op,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            last_byte,
    input  wire logic [8:0]                      read_address,
    output logic                                 wr_en,
    output logic      [$clog2(BUFFER_BYTES)-1:0] wr_addr,
    output logic      [7:0]                      wr_data,
    output logic                                 rd_en,
    output logic      [$clog2(BUFFER_BYTES)-1:0] rd_addr,
    output logic                                 res_valid,
    output result_t                              res
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    localparam int CAP    = BUFFER_BYTES + HEADER_BYTES + 1;
    localparam int POS_W  = $clog2(CAP + 1);
    localparam int SUM_W  = POS_W + 1;

    logic [7:0]       magic_reg;
    logic [15:0]      frame_id_reg,  frame_id_next;
    logic [7:0]       next_idx_reg,  next_idx_next;
    logic [7:0]       total_reg,     total_next;
    logic [LEN_W-1:0] len_reg,       len_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [31:0]      hdr_reg,       hdr_next;
    verdict_t         verdict_reg,   verdict_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg,       res_next;

    logic [31:0]      hdr_shift;
    logic [15:0]      hdr_id;
    logic [7:0]       hdr_idx;
    logic [7:0]       hdr_cnt;
    logic [POS_W-1:0] offset;
    logic [SUM_W-1:0] wr_pos;
    logic [POS_W-1:0] chunk;
    logic [LEN_W-1:0] room;
    logic [7:0]       idx_inc;

    // Frame sequencing and verdict for one accepted transaction.
    always_comb
    begin
        frame_id_next  = frame_id_reg;
        next_idx_next  = next_idx_reg;
        total_next     = total_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        verdict_next   = verdict_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_data        = data_byte;
        rd_en          = 1'b0;
        rd_addr        = ADDR_W'(read_address);

        hdr_shift = {hdr_reg[23:0], data_byte};
        hdr_id    = hdr_shift[31:16];
        hdr_idx   = hdr_shift[15:8];
        hdr_cnt   = hdr_shift[7:0];
        offset    = pos_reg - POS_W'(HEADER_BYTES);
        wr_pos    = SUM_W'(len_reg) + SUM_W'(offset);
        wr_addr   = ADDR_W'(wr_pos);
        chunk     = '0;
        room      = '0;
        idx_inc   = '0;

        if (item_accept && op == OP_READ)
        begin
            // Store read: the data joins the result in the following cycle.
            rd_en              = {23'd0, read_address} < 32'(BUFFER_BYTES);
            res_valid_next     = 1'b1;
            res_next.is_read   = 1'b1;
            res_next.read_data = 8'd0;
            res_next.frame_len = 10'd0;
            res_next.status    = STATUS_ERROR;
        end
        else if (item_accept)
        begin
            // Header bytes, then payload written at its place in the frame.
            if (pos_reg == '0)
            begin
                if (data_byte != magic_reg)
                begin
                    verdict_next = VERDICT_REJECT;
                end
            end
            else if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                hdr_next = hdr_shift;
                if (pos_reg == POS_W'(HEADER_BYTES - 1) && verdict_reg == VERDICT_OK)
                begin
                    if (hdr_cnt == 8'd0 || hdr_idx >= hdr_cnt)
                    begin
                        verdict_next = VERDICT_REJECT;
                    end
                    else if (hdr_idx == 8'd0)
                    begin
                        frame_id_next = hdr_id;
                        next_idx_next = 8'd0;
                        total_next    = hdr_cnt;
                        len_next      = '0;
                    end
                    else if (frame_id_reg != hdr_id || total_reg != hdr_cnt ||
                             next_idx_reg != hdr_idx)
                    begin
                        len_next     = '0;
                        verdict_next = VERDICT_SEQERR;
                    end
                end
            end
            else if (verdict_reg == VERDICT_OK)
            begin
                wr_en = wr_pos < SUM_W'(BUFFER_BYTES);
            end

            if (pos_reg < POS_W'(CAP))
            begin
                pos_next = pos_reg + POS_W'(1);
            end

            // End of fragment: check the fit and give the verdict.
            if (last_byte)
            begin
                res_valid_next     = 1'b1;
                res_next.is_read   = 1'b0;
                res_next.read_data = 8'd0;
                res_next.frame_len = 10'd0;
                res_next.status    = STATUS_ERROR;
                chunk   = pos_next - POS_W'(HEADER_BYTES);
                room    = LEN_W'(BUFFER_BYTES) - len_next;
                idx_inc = next_idx_next + 8'd1;
                if (pos_next >= POS_W'(HEADER_BYTES) && verdict_next == VERDICT_OK)
                begin
                    if (SUM_W'(chunk) > SUM_W'(room))
                    begin
                        len_next = '0;
                    end
                    else
                    begin
                        len_next      = len_next + LEN_W'(chunk);
                        next_idx_next = idx_inc;
                        if (idx_inc == total_next)
                        begin
                            res_next.status    = STATUS_COMPLETE;
                            res_next.frame_len = 10'(len_next);
                        end
                        else
                        begin
                            res_next.status = STATUS_INCOMPLETE;
                        end
                    end
                end
                pos_next     = '0;
                hdr_next     = '0;
                verdict_next = VERDICT_OK;
            end
        end
    end

    // Magic register, frame state and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= 8'd0;
            frame_id_reg  <= 16'd0;
            next_idx_reg  <= 8'd0;
            total_reg     <= 8'd0;
            len_reg       <= '0;
            pos_reg       <= '0;
            hdr_reg       <= 32'd0;
            verdict_reg   <= VERDICT_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                magic_reg <= cfg_data;
            end
            frame_id_reg  <= frame_id_next;
            next_idx_reg  <= next_idx_next;
            total_reg     <= total_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            verdict_reg   <= verdict_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fr_out_queue.sv =====
`default_nettype none

module fr_out_queue
    import fr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_item,
    output logic         can_accept,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    // Room for the result in flight plus one more transaction.
    assign can_accept = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(push)
                        < (CNT_W + 1)'(QUEUE_DEPTH);

    // Pointer and occupancy update.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fragment_reassembler.sv =====
// Throughput: one input transaction per cycle while the result queue has room;
// every stage and the store port take one transaction a cycle, and a
// three-entry result queue absorbs output stalls. Reset is asynchronous and
// active low; it clears the frame state and the magic register, while the
// packet store holds no reset value.
`default_nettype none
`include "assert_macros.svh"

module fragment_reassembler
    import fr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: frame_magic.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], read_address[16:8], zero pad
    input  wire logic        s_tuser,   // op
    input  wire logic        s_tlast,   // last_byte
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // status[1:0], frame_len[11:2],
                                        // read_data[19:12], zero pad
    output logic             m_tuser    // is_read_result
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    logic              item_accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              res_valid;
    result_t           res;
    result_t           push_item;
    result_t           head;

    assign cfg_ready   = 1'b1;
    assign item_accept = s_tvalid && s_tready;

    // Frame sequencing and result generation.
    fr_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .item_accept  (item_accept),
        .op           (s_tuser),
        .data_byte    (s_tdata[7:0]),
        .last_byte    (s_tlast),
        .read_address (s_tdata[16:8]),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Packet store.
    fr_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Merge the store read data into the result.
    always_comb
    begin
        push_item           = res;
        push_item.read_data = rd_data;
    end

    // Result queue in front of the output port.
    fr_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_item  (push_item),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .head       (head)
    );

    assign m_tdata = {4'd0, head.read_data, head.frame_len, head.status};
    assign m_tuser = head.is_read;

    // A read transaction yields a read result in the next cycle.
    `ASSERT_NEXT_CYCLE(a_read_result, clk, rst_n, item_accept && s_tuser == OP_READ,
        res_valid && res.is_read, "read transaction produced no read result")

    // The last byte of a fragment yields a verdict in the next cycle.
    `ASSERT_NEXT_CYCLE(a_frag_verdict, clk, rst_n,
        item_accept && s_tuser == OP_FRAGMENT && s_tlast,
        res_valid && !res.is_read, "fragment end produced no verdict")

    // Read results carry no status and no length.
    `ASSERT_SAME_CYCLE(a_read_fields, clk, rst_n, m_tvalid && m_tuser,
        m_tdata[11:0] == 12'd0, "read result carries verdict fields")

    // A complete verdict never reports more than the store holds.
    `ASSERT_SAME_CYCLE(a_len_bound, clk, rst_n,
        res_valid && res.status == STATUS_COMPLETE,
        32'(res.frame_len) <= 32'(BUFFER_BYTES), "length beyond store size")

endmodule

`default_nettype wire
